>>> rtl/dsh_pkg.sv
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types, constants and helper functions of the diamond-square height
// map generator.
// ----------------------------------------------------------------------------
package dsh_pkg;

  // Default grid side (2^k+1)
  localparam int DEF_GRID_SIDE = 17;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int RAND_W  = 24;
  localparam int COORD_W = 5;
  localparam int KIND_W  = 2;
  localparam int CORNER_W = 2;

  // Request kinds as they arrive on the input channel
  localparam logic [KIND_W-1:0] KIND_CORNER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RANDOM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Height limits
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Nine tenths: 9*r, then divide by ten through a reciprocal
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // Divide by three, one hex digit per cycle
  localparam int          DIV_IN_W   = 34;
  localparam int          DIG_W      = 4;
  localparam int          DIG_N      = 9;
  localparam int          DIV_SH_W   = DIG_W * DIG_N;
  localparam logic [11:0] DIV3_MUL   = 12'd43;
  localparam int          DIV3_SHIFT = 7;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_CORNER,
    OP_RANDOM,
    OP_READ,
    OP_NOP
  } op_t;

  // One queued request
  typedef struct packed {
    op_t                        op;
    logic [CORNER_W-1:0]        corner;
    logic                       in_range;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         column;
    logic signed [VALUE_W-1:0]  value;
    logic [RAND_W-1:0]          add;
  } entry_t;

  // trunc(9*r/10), exact for every 24-bit r
  function automatic logic [RAND_W-1:0] scale_random(input logic [RAND_W-1:0] r);
    logic [RAND_W+3:0]  x;
    logic [RAND_W+35:0] p;
    x = (RAND_W+4)'({r, 3'b000}) + (RAND_W+4)'(r);
    p = (RAND_W+36)'(x) * (RAND_W+36)'(DIV10_MUL);
    return p[DIV10_SHIFT +: RAND_W];
  endfunction

  // Quotient digit of (remainder:digit)/3 for values below 48
  function automatic logic [DIG_W-1:0] div3_digit(input logic [DIG_W+1:0] t);
    logic [11:0] p;
    p = 12'(t) * DIV3_MUL;
    return p[DIV3_SHIFT +: DIG_W];
  endfunction

endpackage

>>> rtl/dsh_if.sv
// ----------------------------------------------------------------------------
// dsh_in_if / dsh_out_if
// Valid/ready channels of the height map generator: request and result.
// ----------------------------------------------------------------------------
interface dsh_in_if;
  logic                                valid;
  logic                                ready;
  logic [dsh_pkg::KIND_W-1:0]          kind;
  logic [dsh_pkg::CORNER_W-1:0]        corner;
  logic signed [dsh_pkg::VALUE_W-1:0]  corner_value;
  logic [dsh_pkg::RAND_W-1:0]          random_value;
  logic [dsh_pkg::COORD_W-1:0]         row;
  logic [dsh_pkg::COORD_W-1:0]         column;

  modport source (
    output valid, kind, corner, corner_value, random_value, row, column,
    input  ready
  );
  modport sink (
    input  valid, kind, corner, corner_value, random_value, row, column,
    output ready
  );
endinterface

interface dsh_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dsh_pkg::VALUE_W-1:0]  cell_value;
  logic                                finished;
  logic                                status;

  modport source (
    output valid, cell_value, finished, status,
    input  ready
  );
  modport sink (
    input  valid, cell_value, finished, status,
    output ready
  );
endinterface

>>> rtl/dsh_ram.sv
// ----------------------------------------------------------------------------
// dsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsh_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/dsh_fifo.sv
// ----------------------------------------------------------------------------
// dsh_fifo
// Short request queue between the front and the back of the generator.
// ----------------------------------------------------------------------------
module dsh_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = dsh_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/dsh_div3.sv
// ----------------------------------------------------------------------------
// dsh_div3
// Signed divide by three, truncating toward zero; one hex digit per cycle.
// ----------------------------------------------------------------------------
module dsh_div3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [dsh_pkg::DIV_IN_W-1:0] dividend,
  output logic                                done,
  output logic signed [dsh_pkg::VALUE_W-1:0]  quotient
);

  localparam int IN_W  = dsh_pkg::DIV_IN_W;
  localparam int SH_W  = dsh_pkg::DIV_SH_W;
  localparam int DW    = dsh_pkg::DIG_W;
  localparam int CNT_W = $clog2(dsh_pkg::DIG_N);
  localparam int VW    = dsh_pkg::VALUE_W;

  typedef enum logic [1:0] {
    D_IDLE,
    D_ABS,
    D_RUN,
    D_FIN
  } dstate_t;

  dstate_t                st_r, st_nxt;
  logic signed [IN_W-1:0] num_r, num_nxt;
  logic                   neg_r, neg_nxt;
  logic [SH_W-1:0]        sh_r, sh_nxt;
  logic [SH_W-1:0]        quo_r, quo_nxt;
  logic [1:0]             rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic signed [VW-1:0]   res_r, res_nxt;

  logic [IN_W-1:0]        mag;
  logic [DW+1:0]          t;
  logic [DW-1:0]          qd;
  logic [DW+1:0]          back3;
  logic [DW+1:0]          r6;
  logic [VW:0]            q33;

  assign done     = done_r;
  assign quotient = res_r;

  // Digit step: remainder stays below three
  always_comb begin
    mag   = num_r[IN_W-1] ? IN_W'(-num_r) : IN_W'(num_r);
    t     = {rem_r, sh_r[SH_W-1 -: DW]};
    qd    = dsh_pkg::div3_digit(t);
    back3 = (DW+2)'(qd) + (DW+2)'({qd, 1'b0});
    r6    = t - back3;
    q33   = neg_r ? (VW+1)'(-quo_r[VW:0]) : quo_r[VW:0];
  end

  // Sequence: capture, take magnitude, run digits, restore sign
  always_comb begin
    st_nxt   = st_r;
    num_nxt  = num_r;
    neg_nxt  = neg_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    case (st_r)
      D_IDLE: begin
        if (start) begin
          num_nxt = dividend;
          st_nxt  = D_ABS;
        end
      end
      D_ABS: begin
        neg_nxt = num_r[IN_W-1];
        sh_nxt  = SH_W'(mag);
        quo_nxt = '0;
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = D_RUN;
      end
      D_RUN: begin
        sh_nxt  = {sh_r[SH_W-DW-1:0], {DW{1'b0}}};
        quo_nxt = {quo_r[SH_W-DW-1:0], qd};
        rem_nxt = r6[1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(dsh_pkg::DIG_N - 1)) begin
          st_nxt = D_FIN;
        end
      end
      D_FIN: begin
        res_nxt  = q33[VW-1:0];
        done_nxt = 1'b1;
        st_nxt   = D_IDLE;
      end
      default: begin
        st_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    neg_r <= neg_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/dsh_front.sv
// ----------------------------------------------------------------------------
// dsh_front
// Accepts requests, classifies them, range-checks reads and scales the
// random amount before queueing.
// ----------------------------------------------------------------------------
module dsh_front #(
  parameter int GRID_SIDE = dsh_pkg::DEF_GRID_SIDE
) (
  dsh_in_if.sink           in_ch,
  input  logic             clear_busy,
  output logic             push_valid,
  input  logic             push_ready,
  output dsh_pkg::entry_t  push_data
);

  // Hold requests off while the grid is being cleared
  assign in_ch.ready = push_ready && !clear_busy;
  assign push_valid  = in_ch.valid && !clear_busy;

  // Classify and prepare the queued entry
  always_comb begin
    case (in_ch.kind)
      dsh_pkg::KIND_CORNER: push_data.op = dsh_pkg::OP_CORNER;
      dsh_pkg::KIND_RANDOM: push_data.op = dsh_pkg::OP_RANDOM;
      dsh_pkg::KIND_READ:   push_data.op = dsh_pkg::OP_READ;
      default:              push_data.op = dsh_pkg::OP_NOP;
    endcase
    push_data.corner   = in_ch.corner;
    push_data.in_range = (int'(in_ch.row) < GRID_SIDE) && (int'(in_ch.column) < GRID_SIDE);
    push_data.row      = in_ch.row;
    push_data.column   = in_ch.column;
    push_data.value    = in_ch.corner_value;
    push_data.add      = dsh_pkg::scale_random(in_ch.random_value);
  end

endmodule

>>> rtl/dsh_back.sv
// ----------------------------------------------------------------------------
// dsh_back
// Executes queued requests on the height grid: corner loads, reads,
// diamond points and square passes, and returns one result per request.
// ----------------------------------------------------------------------------
module dsh_back #(
  parameter int GRID_SIDE = dsh_pkg::DEF_GRID_SIDE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dsh_pkg::entry_t  q_data,
  output logic             q_pop,
  output logic             clear_busy,
  dsh_out_if.source        out_ch
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIDE) + 1;
  localparam int PW    = AW + CW;
  localparam int VW    = dsh_pkg::VALUE_W;
  localparam int DIW   = dsh_pkg::DIV_IN_W;
  localparam logic [CW-1:0] LAST      = CW'(GRID_SIDE - 1);
  localparam logic          DONE_INIT = (GRID_SIDE <= 2);

  // Fetch slots: four corners then centre
  localparam logic [2:0] FI_TL  = 3'd0;
  localparam logic [2:0] FI_TR  = 3'd1;
  localparam logic [2:0] FI_BL  = 3'd2;
  localparam logic [2:0] FI_BR  = 3'd3;
  localparam logic [2:0] FI_MID = 3'd4;

  // Edge midpoints in write order
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_LEFT   = 2'd2;
  localparam logic [1:0] EDGE_RIGHT  = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH_ADDR,
    S_FETCH_DATA,
    S_DIAM_MEAN,
    S_DIAM_WR,
    S_EDGE_START,
    S_EDGE_WAIT,
    S_SQ_NEXT,
    S_READ_DATA
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]               step_r, step_nxt;
  logic [CW-1:0]               pos_row_r, pos_row_nxt;
  logic [CW-1:0]               pos_col_r, pos_col_nxt;
  logic                        done_r, done_nxt;
  logic                        pass_r, pass_nxt;
  logic [CW-1:0]               base_row_r, base_row_nxt;
  logic [CW-1:0]               base_col_r, base_col_nxt;
  logic [2:0]                  fidx_r, fidx_nxt;
  logic [1:0]                  eidx_r, eidx_nxt;
  logic signed [VW-1:0]        vals_r [5];
  logic signed [VW-1:0]        mean_r, mean_nxt;
  logic [dsh_pkg::RAND_W-1:0]  add_r, add_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]        out_cell_r, out_cell_nxt;
  logic                        out_fin_r, out_fin_nxt;
  logic                        out_stat_r, out_stat_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [VW-1:0]               ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [VW-1:0]               ram_rdata;

  logic                        div_start;
  logic signed [DIW-1:0]       div_in;
  logic                        div_done;
  logic signed [VW-1:0]        div_q;

  logic [CW-1:0]               half;
  logic [CW-1:0]               nxt_col, nxt_row;
  logic                        col_fit, row_fit;
  logic [CW-1:0]               fr, fc, er, ec;
  logic signed [DIW-1:0]       edge_sum;
  logic signed [DIW-1:0]       sum4;
  logic signed [DIW-1:0]       mean_full;
  logic signed [DIW:0]         dsum;
  logic signed [VW-1:0]        dsat;
  logic [CW-1:0]               cr, cc;
  logic                        out_free;

  dsh_ram #(
    .W     (VW),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsh_div3 u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [PW-1:0] p;
    p = PW'(r) * PW'(GRID_SIDE) + PW'(c);
    return p[AW-1:0];
  endfunction

  assign clear_busy      = (state_r == S_CLEAR);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.cell_value = out_cell_r;
  assign out_ch.finished = out_fin_r;
  assign out_ch.status   = out_stat_r;
  assign out_free        = !out_valid_r || out_ch.ready;

  // Geometry of the current square and its successor
  always_comb begin
    half    = step_r >> 1;
    nxt_col = base_col_r + step_r;
    nxt_row = base_row_r + step_r;
    col_fit = (nxt_col + step_r) <= LAST;
    row_fit = (nxt_row + step_r) <= LAST;
    cr      = q_data.corner[1] ? LAST : '0;
    cc      = q_data.corner[0] ? LAST : '0;

    case (fidx_r)
      FI_TL: begin fr = base_row_r;          fc = base_col_r;          end
      FI_TR: begin fr = base_row_r;          fc = base_col_r + step_r; end
      FI_BL: begin fr = base_row_r + step_r; fc = base_col_r;          end
      FI_BR: begin fr = base_row_r + step_r; fc = base_col_r + step_r; end
      default: begin fr = base_row_r + half; fc = base_col_r + half;   end
    endcase

    case (eidx_r)
      EDGE_TOP: begin
        er = base_row_r;
        ec = base_col_r + half;
        edge_sum = DIW'(vals_r[FI_TL]) + DIW'(vals_r[FI_TR]) + DIW'(vals_r[FI_MID]);
      end
      EDGE_BOTTOM: begin
        er = base_row_r + step_r;
        ec = base_col_r + half;
        edge_sum = DIW'(vals_r[FI_BL]) + DIW'(vals_r[FI_BR]) + DIW'(vals_r[FI_MID]);
      end
      EDGE_LEFT: begin
        er = base_row_r + half;
        ec = base_col_r;
        edge_sum = DIW'(vals_r[FI_TL]) + DIW'(vals_r[FI_BL]) + DIW'(vals_r[FI_MID]);
      end
      default: begin
        er = base_row_r + half;
        ec = base_col_r + step_r;
        edge_sum = DIW'(vals_r[FI_TR]) + DIW'(vals_r[FI_BR]) + DIW'(vals_r[FI_MID]);
      end
    endcase

    // Mean of four corners, truncated toward zero
    sum4 = DIW'(vals_r[FI_TL]) + DIW'(vals_r[FI_TR])
         + DIW'(vals_r[FI_BL]) + DIW'(vals_r[FI_BR]);
    mean_full = (sum4 + (sum4[DIW-1] ? DIW'(3) : DIW'(0))) >>> 2;

    // Add scaled random amount, saturate to the height range
    dsum = (DIW+1)'(mean_r) + (DIW+1)'(signed'({1'b0, add_r}));
    if (dsum > (DIW+1)'(dsh_pkg::VAL_MAX)) begin
      dsat = dsh_pkg::VAL_MAX;
    end else if (dsum < (DIW+1)'(dsh_pkg::VAL_MIN)) begin
      dsat = dsh_pkg::VAL_MIN;
    end else begin
      dsat = dsum[VW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    done_nxt      = done_r;
    pass_nxt      = pass_r;
    base_row_nxt  = base_row_r;
    base_col_nxt  = base_col_r;
    fidx_nxt      = fidx_r;
    eidx_nxt      = eidx_r;
    mean_nxt      = mean_r;
    add_nxt       = add_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cell_nxt  = out_cell_r;
    out_fin_nxt   = out_fin_r;
    out_stat_nxt  = out_stat_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_of(er, ec);
    ram_wdata     = div_q;
    ram_raddr     = addr_of(fr, fc);
    div_start     = 1'b0;
    div_in        = edge_sum;

    case (state_r)
      // Zero the grid one cell per cycle after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      // Take the next request once the result slot can hold its answer
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop        = 1'b1;
          add_nxt      = q_data.add;
          out_cell_nxt = '0;
          out_fin_nxt  = done_r;
          out_stat_nxt = 1'b0;
          case (q_data.op)
            dsh_pkg::OP_CORNER: begin
              ram_we        = 1'b1;
              ram_waddr     = addr_of(cr, cc);
              ram_wdata     = q_data.value;
              out_valid_nxt = 1'b1;
            end
            dsh_pkg::OP_READ: begin
              if (q_data.in_range) begin
                ram_raddr = addr_of(CW'(q_data.row), CW'(q_data.column));
                state_nxt = S_READ_DATA;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            dsh_pkg::OP_RANDOM: begin
              if (done_r) begin
                out_stat_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                base_row_nxt = pos_row_r;
                base_col_nxt = pos_col_r;
                fidx_nxt     = FI_TL;
                pass_nxt     = 1'b0;
                state_nxt    = S_FETCH_ADDR;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_FETCH_ADDR: begin
        state_nxt = S_FETCH_DATA;
      end

      // Gather corners (and the centre during a square pass)
      S_FETCH_DATA: begin
        if (pass_r && fidx_r == FI_MID) begin
          eidx_nxt  = EDGE_TOP;
          state_nxt = S_EDGE_START;
        end else if (!pass_r && fidx_r == FI_BR) begin
          state_nxt = S_DIAM_MEAN;
        end else begin
          fidx_nxt  = fidx_r + 1'b1;
          state_nxt = S_FETCH_ADDR;
        end
      end

      S_DIAM_MEAN: begin
        mean_nxt  = mean_full[VW-1:0];
        state_nxt = S_DIAM_WR;
      end

      // Write the diamond point, then step to the next square or, after the last one, start the square pass
      S_DIAM_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = addr_of(base_row_r + half, base_col_r + half);
        ram_wdata    = dsat;
        out_cell_nxt = '0;
        out_fin_nxt  = done_r;
        out_stat_nxt = 1'b0;
        if (col_fit) begin
          pos_col_nxt   = nxt_col;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (row_fit) begin
          pos_col_nxt   = '0;
          pos_row_nxt   = nxt_row;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          base_row_nxt = '0;
          base_col_nxt = '0;
          pass_nxt     = 1'b1;
          fidx_nxt     = FI_TL;
          state_nxt    = S_FETCH_ADDR;
        end
      end

      S_EDGE_START: begin
        div_start = 1'b1;
        state_nxt = S_EDGE_WAIT;
      end

      // Write each edge midpoint once its quotient is ready
      S_EDGE_WAIT: begin
        if (div_done) begin
          ram_we = 1'b1;
          if (eidx_r == EDGE_RIGHT) begin
            state_nxt = S_SQ_NEXT;
          end else begin
            eidx_nxt  = eidx_r + 1'b1;
            state_nxt = S_EDGE_START;
          end
        end
      end

      // Advance through the level's squares, close the level at the end
      S_SQ_NEXT: begin
        fidx_nxt = FI_TL;
        if (col_fit) begin
          base_col_nxt = nxt_col;
          state_nxt    = S_FETCH_ADDR;
        end else if (row_fit) begin
          base_col_nxt = '0;
          base_row_nxt = nxt_row;
          state_nxt    = S_FETCH_ADDR;
        end else begin
          step_nxt      = half;
          pos_row_nxt   = '0;
          pos_col_nxt   = '0;
          done_nxt      = (half <= CW'(1));
          pass_nxt      = 1'b0;
          out_cell_nxt  = '0;
          out_fin_nxt   = (half <= CW'(1));
          out_stat_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_READ_DATA: begin
        out_cell_nxt  = ram_rdata;
        out_fin_nxt   = done_r;
        out_stat_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= LAST;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      done_r      <= DONE_INIT;
      pass_r      <= 1'b0;
      fidx_r      <= FI_TL;
      eidx_r      <= EDGE_TOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      done_r      <= done_nxt;
      pass_r      <= pass_nxt;
      fidx_r      <= fidx_nxt;
      eidx_r      <= eidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_row_r <= base_row_nxt;
    base_col_r <= base_col_nxt;
    mean_r     <= mean_nxt;
    add_r      <= add_nxt;
    out_cell_r <= out_cell_nxt;
    out_fin_r  <= out_fin_nxt;
    out_stat_r <= out_stat_nxt;
    if (state_r == S_FETCH_DATA) begin
      vals_r[fidx_r] <= ram_rdata;
    end
  end

endmodule

>>> rtl/diamond_square_heightmap_top.sv
// The last diamond of a level adds a square pass over every square of the level
//   (edge midpoints go through a divide by 3).
// Throughput: one request in flight in the back end; a 2-entry queue and an
//   output register let requests and results move while it works.
// Reset: synchronous; the grid memory is zeroed cell by cell after reset,
//   during which no request is accepted.
// ----------------------------------------------------------------------------
// diamond_square_heightmap_top
// Diamond-square height map generator: front classifier, request queue and
// grid execution engine.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_top #(
  parameter int GRID_SIDE = dsh_pkg::DEF_GRID_SIDE
) (
  input  logic       clk,
  input  logic       rst_n,
  dsh_in_if.sink     in_ch,
  dsh_out_if.source  out_ch
);

  localparam int EW = $bits(dsh_pkg::entry_t);

  logic             push_valid;
  logic             push_ready;
  dsh_pkg::entry_t  push_data;
  logic             q_valid;
  logic             q_pop;
  dsh_pkg::entry_t  q_data;
  logic             clear_busy;

  dsh_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .in_ch      (in_ch),
    .clear_busy (clear_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dsh_fifo #(
    .W     (EW),
    .DEPTH (dsh_pkg::FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  dsh_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

endmodule
